FILE: rtl/range_common_divisor_count_defines.svh
// Assertion macros shared by the RTL of the range divisor count block.
`ifndef RANGE_COMMON_DIVISOR_COUNT_DEFINES_SVH
`define RANGE_COMMON_DIVISOR_COUNT_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define RCD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define RCD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: rtl/rcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcd_pkg
// Types and constants of the range common divisor count block.
// ----------------------------------------------------------------------------
package rcd_pkg;
	localparam int IDX_W = 10;
	localparam int NODE_W = 11;
	localparam int VAL_W = 31;
	localparam int CNT_W = 11;
	localparam int MAX_ELEMENTS = 1024;
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic action;
		logic [IDX_W-1:0] element_index;
		logic [VAL_W-1:0] element_value;
		logic [IDX_W-1:0] range_left;
		logic [IDX_W-1:0] range_right;
	} in_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] divider_count;
		logic [CNT_W-1:0] other_count;
		logic range_error;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LRD, ST_LMERGE, ST_QSTEP, ST_QRD, ST_MERGE, ST_GCD,
		ST_FIN, ST_WB, ST_OUT, ST_CLR
	} state_t;
endpackage
`default_nettype wire

FILE: rtl/rcd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcd_in_if / rcd_out_if / rcd_cfg_if
// Valid/ready channels of the range common divisor count block.
// ----------------------------------------------------------------------------
interface rcd_in_if;
	import rcd_pkg::*;
	logic valid;
	logic ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rcd_out_if;
	import rcd_pkg::*;
	logic valid;
	logic ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rcd_cfg_if;
	logic valid;
	logic ready;
	logic [10:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/range_common_divisor_count.sv
`default_nettype none
`include "range_common_divisor_count_defines.svh"
// ----------------------------------------------------------------------------
// range_common_divisor_count
// Segment tree of (gcd, count) pairs answering range divisor count queries.
// ----------------------------------------------------------------------------
// After reset a clearing pass sets every tree node to a divisor of zero with a
// count equal to its span; no item is accepted meanwhile. A load writes its
// leaf in the cycle it is accepted and then walks the ten levels up to the
// root: at each level the sibling is read from the node memory, merged with
// the running value by a shared binary GCD unit that retires one step per
// cycle, and the parent is written back. A query walks the same levels from
// both range ends and merges up to two nodes per level; a query with an
// invalid range is answered with the range error flag set and zero counts.
// A result waits in an output register, and no item is accepted until it is
// taken.
module range_common_divisor_count (
	input wire logic clk,
	input wire logic arst_n,
	rcd_in_if.sink in_ch,
	rcd_cfg_if.sink cfg_ch,
	rcd_out_if.source out_ch
);
	import rcd_pkg::*;

	// Node memory: gcd and count per node, index 1..2047.
	logic [VAL_W-1:0] mem_g [0:2*MAX_ELEMENTS-1];
	logic [CNT_W-1:0] mem_c [0:2*MAX_ELEMENTS-1];
	logic [VAL_W-1:0] rd_g_q;
	logic [CNT_W-1:0] rd_c_q;
	logic [NODE_W-1:0] raddr, waddr;
	logic we;
	logic [VAL_W-1:0] wg;
	logic [CNT_W-1:0] wc;

	state_t state_q, state_d;
	in_item_t item_q;
	logic [CNT_W-1:0] ecount_q;
	logic [NODE_W:0] lo_q, hi_q;     // one extra bit: hi may reach 2048
	logic [NODE_W-1:0] node_q;       // load walk position
	logic side_q;                    // query: 0 left node, 1 right node
	// Accumulator and operand of the merge.
	logic [VAL_W-1:0] acc_g_q, opb_g_q;
	logic [CNT_W-1:0] acc_c_q, opb_c_q;
	// Binary GCD working registers.
	logic [VAL_W-1:0] ga_q, gb_q;
	logic [4:0] sh_q;
	out_item_t out_q;
	logic out_v_q;
	logic [NODE_W-1:0] clr_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_g[waddr] <= wg;
			mem_c[waddr] <= wc;
		end
		rd_g_q <= mem_g[raddr];
		rd_c_q <= mem_c[raddr];
	end

	// Count for a cleared node: span of the node at its level.
	function automatic logic [CNT_W-1:0] span_of(input logic [NODE_W-1:0] n);
		logic [CNT_W-1:0] s;
		s = CNT_W'(1);
		// The highest set bit gives the level, so it is applied last.
		for (int b = 0; b < NODE_W; b++) begin
			if (n[b]) s = CNT_W'(1) << (NODE_W-1-b);
		end
		return s;
	endfunction

	logic lo_odd, hi_odd;
	assign lo_odd = lo_q[0];
	assign hi_odd = hi_q[0];
	logic bad;
	assign bad = (item_q.range_left > item_q.range_right) ||
		({1'b0, item_q.range_right} >= ecount_q);
	logic [VAL_W-1:0] gres;
	assign gres = ga_q << sh_q;

	always_comb begin
		state_d = state_q;
		raddr = node_q;
		we = 1'b0;
		waddr = node_q;
		wg = acc_g_q;
		wc = acc_c_q;
		in_ch.ready = (state_q == ST_IDLE) && !out_v_q;
		cfg_ch.ready = 1'b1;
		case (state_q)
			ST_CLR: begin
				we = 1'b1;
				waddr = clr_q;
				wg = '0;
				wc = span_of(clr_q);
				if (clr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_ch.valid && !out_v_q) begin
					if (in_ch.data.action == ACT_LOAD) begin
						// The leaf is written now; the walk rebuilds its ancestors.
						we = 1'b1;
						waddr = NODE_W'(MAX_ELEMENTS) + NODE_W'(in_ch.data.element_index);
						wg = in_ch.data.element_value;
						wc = CNT_W'(1);
						state_d = ST_LRD;
					end else state_d = ST_QSTEP;
				end
			end
			ST_LRD: begin
				raddr = node_q ^ NODE_W'(1);
				state_d = ST_LMERGE;
			end
			ST_LMERGE: state_d = ST_GCD;
			ST_QSTEP: begin
				if (bad) state_d = ST_IDLE;
				else if (lo_q >= hi_q) state_d = ST_OUT;
				else if (!side_q && lo_odd) begin
					raddr = lo_q[NODE_W-1:0];
					state_d = ST_QRD;
				end else if (side_q && hi_odd) begin
					raddr = hi_q[NODE_W-1:0] - NODE_W'(1);
					state_d = ST_QRD;
				end
			end
			ST_QRD: begin
				// Keep the address so that the node is still on the read port.
				raddr = side_q ? (hi_q[NODE_W-1:0] - NODE_W'(1)) : lo_q[NODE_W-1:0];
				state_d = ST_MERGE;
			end
			ST_MERGE: state_d = ST_GCD;
			ST_GCD: if (gb_q == '0) state_d = ST_FIN;
			ST_FIN: begin
				if (item_q.action == ACT_LOAD) state_d = ST_WB;
				else state_d = ST_QSTEP;
			end
			ST_WB: begin
				we = 1'b1;
				waddr = node_q >> 1;
				if ((node_q >> 1) == NODE_W'(1)) state_d = ST_IDLE;
				else state_d = ST_LRD;
			end
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			out_v_q <= 1'b0;
			ecount_q <= CNT_W'(1);
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) clr_q <= clr_q + NODE_W'(1);
			if (cfg_ch.valid && cfg_ch.ready) ecount_q <= cfg_ch.data;
			if (out_ch.valid && out_ch.ready) out_v_q <= 1'b0;
			if (state_q == ST_OUT || (state_q == ST_QSTEP && bad)) out_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				item_q <= in_ch.data;
				node_q <= NODE_W'(MAX_ELEMENTS) + NODE_W'(in_ch.data.element_index);
				// A load starts from its own leaf, a query from the merge identity.
				if (in_ch.data.action == ACT_LOAD) begin
					acc_g_q <= in_ch.data.element_value;
					acc_c_q <= CNT_W'(1);
				end else begin
					acc_g_q <= '0;
					acc_c_q <= '0;
				end
				lo_q <= (NODE_W+1)'(MAX_ELEMENTS) + (NODE_W+1)'(in_ch.data.range_left);
				hi_q <= (NODE_W+1)'(MAX_ELEMENTS) + (NODE_W+1)'(in_ch.data.range_right)
					+ (NODE_W+1)'(1);
				side_q <= 1'b0;
			end
			ST_LMERGE, ST_MERGE: begin
				opb_g_q <= rd_g_q;
				opb_c_q <= rd_c_q;
				ga_q <= acc_g_q;
				gb_q <= rd_g_q;
				sh_q <= '0;
			end
			ST_GCD: begin
				// Binary GCD, one step per cycle; zero operands end at once.
				if (ga_q == '0) begin
					ga_q <= gb_q;
					gb_q <= '0;
				end else if (gb_q != '0) begin
					if (!ga_q[0] && !gb_q[0]) begin
						ga_q <= ga_q >> 1;
						gb_q <= gb_q >> 1;
						sh_q <= sh_q + 5'(1);
					end else if (!ga_q[0]) ga_q <= ga_q >> 1;
					else if (!gb_q[0]) gb_q <= gb_q >> 1;
					else if (ga_q >= gb_q) ga_q <= (ga_q - gb_q) >> 1;
					else gb_q <= (gb_q - ga_q) >> 1;
				end
			end
			ST_FIN: begin
				acc_g_q <= gres;
				acc_c_q <= ((acc_g_q == gres) ? acc_c_q : '0) +
					((opb_g_q == gres) ? opb_c_q : '0);
				if (item_q.action == ACT_QUERY) begin
					if (!side_q) lo_q <= lo_q + (NODE_W+1)'(1);
					else hi_q <= hi_q - (NODE_W+1)'(1);
				end
			end
			ST_WB: node_q <= node_q >> 1;
			ST_QSTEP: begin
				if (bad) begin
					out_q <= '{divider_count: '0, other_count: '0, range_error: 1'b1};
				end else if (lo_q < hi_q && !(side_q ? hi_odd : lo_odd)) begin
					if (side_q) begin
						lo_q <= lo_q >> 1;
						hi_q <= hi_q >> 1;
					end
					side_q <= !side_q;
				end
			end
			ST_OUT: begin
				out_q.divider_count <= acc_c_q;
				out_q.other_count <= CNT_W'(item_q.range_right - item_q.range_left)
					+ CNT_W'(1) - acc_c_q;
				out_q.range_error <= 1'b0;
			end
			default: ;
		endcase
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.data = out_q;

	`RCD_ASSERT_IMP(a_busy_not_ready, state_q != ST_IDLE, !in_ch.ready)
	`RCD_ASSERT_IMP(a_out_hold_not_ready, out_v_q, !in_ch.ready)
	`RCD_ASSERT_NEXT(a_out_stable, out_v_q && !out_ch.ready, out_v_q && $stable(out_q))
endmodule
`default_nettype wire
